/* design/trcf_pkg.sv */
`timescale 1ns / 1ps

package trcf_pkg;

   localparam int FIELD_LEN_W = 13;

   localparam logic [1:0] CMD_SEGMENT = 2'd0;
   localparam logic [1:0] CMD_LISTEN  = 2'd1;
   localparam logic [1:0] CMD_CONSUME = 2'd2;
   localparam logic [1:0] CMD_TICK    = 2'd3;

   localparam logic [2:0] SEG_SYN  = 3'd0;
   localparam logic [2:0] SEG_FIN  = 3'd2;
   localparam logic [2:0] SEG_DATA = 3'd4;

   localparam logic [1:0] REPLY_SYNACK  = 2'd0;
   localparam logic [1:0] REPLY_FINACK  = 2'd1;
   localparam logic [1:0] REPLY_DATAACK = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;
   localparam logic [1:0] STATUS_NO_SLOT = 2'd3;

   localparam logic [1:0] CONN_CLOSED = 2'd0;
   localparam logic [1:0] CONN_LISTEN = 2'd1;
   localparam logic [1:0] CONN_OPEN   = 2'd2;
   localparam logic [1:0] CONN_CWAIT  = 2'd3;

   localparam logic [2:0] REG_ENABLE    = 3'd0;
   localparam logic [2:0] REG_PORT0     = 3'd1;
   localparam logic [2:0] REG_CLOSEWAIT = 3'd5;

   localparam logic [15:0] CLOSEWAIT_RESET = 16'd100;

   typedef struct packed {
      logic [FIELD_LEN_W-1:0] read_length;
      logic [FIELD_LEN_W-1:0] seg_length;
      logic [31:0]            seq_num;
      logic [15:0]            to_port;
      logic [15:0]            from_port;
      logic [7:0]             src_node;
      logic [2:0]             seg_type;
      logic [1:0]             slot;
   } req_data_type;

   typedef struct packed {
      logic [FIELD_LEN_W-1:0] buffered_bytes;
      logic [1:0]             slot_state;
      logic [1:0]             status;
      logic [31:0]            reply_ack_num;
      logic [15:0]            reply_from_port;
      logic [15:0]            reply_to_port;
      logic [7:0]             reply_node;
      logic                   reply_valid;
   } rsp_data_type;

   typedef struct packed {
      logic [1:0]             conn_state;
      logic [7:0]             peer_node;
      logic [15:0]            peer_port;
      logic [31:0]            expected_seq;
      logic [FIELD_LEN_W-1:0] used_bytes;
      logic [15:0]            closewait_count;
   } slot_entry_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_op_type;

   typedef struct packed {
      logic [31:0] result;
      logic        borrow;
      logic        zero;
   } alu_res_type;

endpackage

/* design/trcf_alu.sv */
`timescale 1ns / 1ps

module trcf_alu
   import trcf_pkg::*;
(
   input  alu_op_type  op,
   output alu_res_type res
);

   logic [31:0] b_eff;
   logic [32:0] sum;

   assign b_eff = op.sub ? ~op.b : op.b;
   assign sum   = {1'b0, op.a} + {1'b0, b_eff} + {32'd0, op.sub};

   assign res.result = sum[31:0];
   assign res.borrow = op.sub ? ~sum[32] : sum[32];
   assign res.zero   = (sum[31:0] == 32'd0);

endmodule

/* design/trcf_slot_table.sv */
`timescale 1ns / 1ps

module trcf_slot_table
   import trcf_pkg::*;
#(
   parameter int SLOTS  = 4,
   parameter int SLOT_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] idx,
   output slot_entry_type    rd_entry,
   input  logic              wr_en,
   input  slot_entry_type    wr_entry
);

   slot_entry_type entries_ff [SLOTS];
   slot_entry_type entries_in [SLOTS];

   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (idx == SLOT_W'(i)) begin
            rd_entry = entries_ff[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         entries_in[i] = entries_ff[i];
         if (wr_en && idx == SLOT_W'(i)) begin
            entries_in[i] = wr_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < SLOTS; i++) begin
         if (reset) begin
            entries_ff[i] <= '0;
         end else begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

endmodule

/* design/transport_receiver_connection_fsm.sv */
// listen and consume go from idle straight to the execute state; segment and tick first
// scan the slots, one slot per cycle through the shared adder, before the execute state
// req_tready is high only when idle; the execute state waits for a free result register,
// and the result register frees the input side once the item is held there
// reset: synchronous, active high; all slots closed and zeroed, ports and enables 0,
// close wait ticks 100
`timescale 1ns / 1ps

module transport_receiver_connection_fsm
   import trcf_pkg::*;
#(
   parameter int SLOTS     = 4,
   parameter int BUF_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // slot, seg_type, src_node, from_port, to_port,
                                    // seq_num, seg_length, read_length
   input  logic [1:0]   req_tuser,  // cmd
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,  // reply_valid, reply_node, reply_to_port,
                                    // reply_from_port, reply_ack_num, status, slot_state,
                                    // buffered_bytes
   output logic [1:0]   rsp_tuser,  // reply_type
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [FIELD_LEN_W:0] BUF_LIMIT = (FIELD_LEN_W + 1)'(BUF_BYTES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   // configuration
   logic [SLOTS-1:0] enable_ff, enable_in;
   logic [15:0]      port_ff [SLOTS];
   logic [15:0]      port_in [SLOTS];
   logic [15:0]      closewait_ff, closewait_in;

   assign csr_ready = !reset;

   always_comb begin
      enable_in    = enable_ff;
      closewait_in = closewait_ff;
      for (int i = 0; i < SLOTS; i++) begin
         port_in[i] = port_ff[i];
      end
      if (csr_valid) begin
         unique case (csr_index)
            REG_ENABLE: begin
               enable_in = csr_data[SLOTS-1:0];
            end
            REG_CLOSEWAIT: begin
               closewait_in = csr_data;
            end
            default: begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (csr_index == REG_PORT0 + 3'(i)) begin
                     port_in[i] = csr_data;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= '0;
         closewait_ff <= CLOSEWAIT_RESET;
         for (int i = 0; i < SLOTS; i++) begin
            port_ff[i] <= '0;
         end
      end else begin
         enable_ff    <= enable_in;
         closewait_ff <= closewait_in;
         for (int i = 0; i < SLOTS; i++) begin
            port_ff[i] <= port_in[i];
         end
      end
   end

   // sequencer
   logic [1:0]        state_ff, state_in;
   logic [1:0]        cmd_ff, cmd_in;
   req_data_type      req_ff, req_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_ff, rsp_in;
   logic [1:0]        rtype_ff, rtype_in;

   alu_op_type        alu_op;
   alu_res_type       alu_res;
   slot_entry_type    rd_entry;
   slot_entry_type    wr_entry;
   logic              wr_en;

   logic              slot_bad;
   logic              slot_ok;
   logic              last_slot;
   logic              exec_go;
   logic [FIELD_LEN_W:0] fill_sum;

   trcf_alu u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   trcf_slot_table #(
      .SLOTS  (SLOTS),
      .SLOT_W (SLOT_W)
   ) u_slot_table (
      .clock    (clock),
      .reset    (reset),
      .idx      (idx_ff),
      .rd_entry (rd_entry),
      .wr_en    (wr_en),
      .wr_entry (wr_entry)
   );

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ff};
   assign rsp_tuser  = rtype_ff;

   assign slot_bad  = ({1'b0, req_ff.slot} >= 3'(SLOTS));
   assign slot_ok   = !slot_bad && enable_ff[idx_ff];
   assign last_slot = (idx_ff == SLOT_W'(SLOTS - 1));
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);
   assign fill_sum  = {1'b0, rd_entry.used_bytes} + {1'b0, req_ff.seg_length};

   always_comb begin
      alu_op = '0;
      if (state_ff == ST_SCAN) begin
         alu_op.sub = 1'b1;
         if (cmd_ff == CMD_TICK) begin
            alu_op.a = {16'd0, rd_entry.closewait_count};
            alu_op.b = 32'd1;
         end else begin
            alu_op.a = {16'd0, port_ff[idx_ff]};
            alu_op.b = {16'd0, req_ff.to_port};
         end
      end else if (cmd_ff == CMD_CONSUME) begin
         alu_op.sub = 1'b1;
         alu_op.a   = {19'd0, rd_entry.used_bytes};
         alu_op.b   = {19'd0, req_ff.read_length};
      end else begin
         alu_op.a = req_ff.seq_num;
         alu_op.b = {19'd0, req_ff.seg_length};
      end
   end

   always_comb begin
      logic [1:0] status;
      logic       reply;
      logic [1:0] rtype;
      logic       have;

      state_in     = state_ff;
      cmd_in       = cmd_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      found_in     = found_ff;
      rsp_in       = rsp_ff;
      rtype_in     = rtype_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_entry     = rd_entry;
      status       = STATUS_OK;
      reply        = 1'b0;
      rtype        = REPLY_SYNACK;
      have         = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in   = req_tuser;
               req_in   = req_data_type'(req_tdata[102:0]);
               found_in = 1'b0;
               if (req_tuser == CMD_SEGMENT || req_tuser == CMD_TICK) begin
                  idx_in   = '0;
                  state_in = ST_SCAN;
               end else begin
                  idx_in   = req_in.slot[SLOT_W-1:0];
                  state_in = ST_EXEC;
               end
            end
         end
         ST_SCAN: begin
            if (cmd_ff == CMD_TICK) begin
               if (rd_entry.conn_state == CONN_CWAIT) begin
                  wr_en = 1'b1;
                  if (alu_res.zero || alu_res.borrow) begin
                     wr_entry.closewait_count = '0;
                     wr_entry.conn_state      = CONN_CLOSED;
                     wr_entry.used_bytes      = '0;
                  end else begin
                     wr_entry.closewait_count = alu_res.result[15:0];
                  end
               end
               if (last_slot) begin
                  idx_in   = req_ff.slot[SLOT_W-1:0];
                  state_in = ST_EXEC;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end else begin
               if (enable_ff[idx_ff] && alu_res.zero) begin
                  found_in = 1'b1;
                  state_in = ST_EXEC;
               end else if (last_slot) begin
                  state_in = ST_EXEC;
               end else begin
                  idx_in = idx_ff + SLOT_W'(1);
               end
            end
         end
         ST_EXEC: begin
            case (cmd_ff)
               CMD_SEGMENT: begin
                  have = found_ff;
                  if (!found_ff) begin
                     status = STATUS_NO_SLOT;
                  end else begin
                     status = STATUS_REFUSED;
                     case (rd_entry.conn_state)
                        CONN_LISTEN: begin
                           if (req_ff.seg_type == SEG_SYN) begin
                              wr_en                 = 1'b1;
                              wr_entry.peer_node    = req_ff.src_node;
                              wr_entry.peer_port    = req_ff.from_port;
                              wr_entry.expected_seq = req_ff.seq_num;
                              wr_entry.conn_state   = CONN_OPEN;
                              status                = STATUS_OK;
                              reply                 = 1'b1;
                              rtype                 = REPLY_SYNACK;
                           end
                        end
                        CONN_OPEN: begin
                           if (rd_entry.peer_node == req_ff.src_node &&
                               rd_entry.peer_port == req_ff.from_port) begin
                              if (req_ff.seg_type == SEG_SYN) begin
                                 wr_en                 = 1'b1;
                                 wr_entry.expected_seq = req_ff.seq_num;
                                 status                = STATUS_OK;
                                 reply                 = 1'b1;
                                 rtype                 = REPLY_SYNACK;
                              end else if (req_ff.seg_type == SEG_DATA) begin
                                 status = STATUS_OK;
                                 if (req_ff.seq_num != rd_entry.expected_seq) begin
                                    reply = 1'b1;
                                    rtype = REPLY_DATAACK;
                                 end else if (fill_sum < BUF_LIMIT) begin
                                    wr_en                 = 1'b1;
                                    wr_entry.used_bytes   = fill_sum[FIELD_LEN_W-1:0];
                                    wr_entry.expected_seq = alu_res.result;
                                    reply                 = 1'b1;
                                    rtype                 = REPLY_DATAACK;
                                 end
                              end else if (req_ff.seg_type == SEG_FIN) begin
                                 wr_en                    = 1'b1;
                                 wr_entry.conn_state      = CONN_CWAIT;
                                 wr_entry.closewait_count = closewait_ff;
                                 status                   = STATUS_OK;
                                 reply                    = 1'b1;
                                 rtype                    = REPLY_FINACK;
                              end
                           end
                        end
                        CONN_CWAIT: begin
                           if (req_ff.seg_type == SEG_FIN) begin
                              status = STATUS_OK;
                              reply  = 1'b1;
                              rtype  = REPLY_FINACK;
                           end
                        end
                        default: begin
                           status = STATUS_REFUSED;
                        end
                     endcase
                  end
               end
               CMD_LISTEN: begin
                  have = !slot_bad;
                  if (!slot_ok || rd_entry.conn_state != CONN_CLOSED) begin
                     status = STATUS_REFUSED;
                  end else begin
                     wr_en               = 1'b1;
                     wr_entry.conn_state = CONN_LISTEN;
                  end
               end
               CMD_CONSUME: begin
                  have = !slot_bad;
                  if (!slot_ok || rd_entry.conn_state != CONN_OPEN) begin
                     status = STATUS_REFUSED;
                  end else if (alu_res.borrow) begin
                     status = STATUS_SHORT;
                  end else begin
                     wr_en               = 1'b1;
                     wr_entry.used_bytes = alu_res.result[FIELD_LEN_W-1:0];
                  end
               end
               default: begin
                  have = !slot_bad;
               end
            endcase

            wr_en = wr_en && exec_go;
            if (exec_go) begin
               rsp_valid_in           = 1'b1;
               rsp_in                 = '0;
               rtype_in               = '0;
               rsp_in.status          = status;
               if (reply) begin
                  rsp_in.reply_valid     = 1'b1;
                  rtype_in               = rtype;
                  rsp_in.reply_node      = wr_entry.peer_node;
                  rsp_in.reply_to_port   = wr_entry.peer_port;
                  rsp_in.reply_from_port = port_ff[idx_ff];
                  if (rtype == REPLY_DATAACK) begin
                     rsp_in.reply_ack_num = wr_entry.expected_seq;
                  end
               end
               if (have) begin
                  rsp_in.slot_state     = wr_entry.conn_state;
                  rsp_in.buffered_bytes = wr_entry.used_bytes;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         cmd_ff       <= CMD_SEGMENT;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         cmd_ff       <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      rsp_ff   <= rsp_in;
      rtype_ff <= rtype_in;
   end

endmodule

/* bench/trcf_reply_checker.sv */
`timescale 1ns / 1ps

module trcf_reply_checker
   import trcf_pkg::*;
#(
   parameter int SLOTS     = 4,
   parameter int BUF_BYTES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [103:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int           outstanding,
   output int           fail_count
);

   typedef struct packed {
      logic [1:0]   reply_type;
      rsp_data_type body;
   } reply_item_type;

   reply_item_type expected_replies[$];
   reply_item_type want;
   rsp_data_type   seen;

   logic [3:0]     enable_bits;
   logic [15:0]    local_port [SLOTS];
   logic [15:0]    closewait_reload;
   slot_entry_type conn [SLOTS];

   initial fail_count = 0;

   function automatic logic slot_on(input int s);
      return s < SLOTS && enable_bits[s];
   endfunction

   // built after the slot state is updated
   function automatic reply_item_type answer(input int s, input logic [1:0] kind);
      reply_item_type r;
      r = '0;
      r.reply_type = kind;
      r.body.reply_valid = 1'b1;
      r.body.reply_node = conn[s].peer_node;
      r.body.reply_to_port = conn[s].peer_port;
      r.body.reply_from_port = local_port[s];
      r.body.reply_ack_num = (kind == REPLY_DATAACK) ? conn[s].expected_seq : 32'd0;
      return r;
   endfunction

   function automatic reply_item_type predict_reply(input logic [1:0] cmd,
                                                    input req_data_type d);
      reply_item_type r;
      int s;
      logic hit;
      logic [1:0] st;
      int fill;
      r = '0;
      s = d.slot;
      hit = 1'b1;
      st = STATUS_OK;
      case (cmd)
         CMD_SEGMENT: begin
            hit = 1'b0;
            // lowest enabled slot with a matching port wins
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (slot_on(i) && local_port[i] == d.to_port) begin
                  s = i;
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               st = STATUS_NO_SLOT;
            end else begin
               st = STATUS_REFUSED;
               case (conn[s].conn_state)
                  CONN_LISTEN: begin
                     if (d.seg_type == SEG_SYN) begin
                        conn[s].peer_node = d.src_node;
                        conn[s].peer_port = d.from_port;
                        conn[s].expected_seq = d.seq_num;
                        conn[s].conn_state = CONN_OPEN;
                        r = answer(s, REPLY_SYNACK);
                        st = STATUS_OK;
                     end
                  end
                  CONN_OPEN: begin
                     if (conn[s].peer_node == d.src_node &&
                         conn[s].peer_port == d.from_port) begin
                        if (d.seg_type == SEG_SYN) begin
                           conn[s].expected_seq = d.seq_num;
                           r = answer(s, REPLY_SYNACK);
                           st = STATUS_OK;
                        end else if (d.seg_type == SEG_DATA) begin
                           st = STATUS_OK;
                           fill = conn[s].used_bytes + d.seg_length;
                           if (d.seq_num != conn[s].expected_seq) begin
                              r = answer(s, REPLY_DATAACK);
                           end else if (fill < BUF_BYTES) begin
                              conn[s].used_bytes = fill[FIELD_LEN_W-1:0];
                              conn[s].expected_seq = d.seq_num + d.seg_length;
                              r = answer(s, REPLY_DATAACK);
                           end
                        end else if (d.seg_type == SEG_FIN) begin
                           conn[s].conn_state = CONN_CWAIT;
                           conn[s].closewait_count = closewait_reload;
                           r = answer(s, REPLY_FINACK);
                           st = STATUS_OK;
                        end
                     end
                  end
                  CONN_CWAIT: begin
                     if (d.seg_type == SEG_FIN) begin
                        r = answer(s, REPLY_FINACK);
                        st = STATUS_OK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         CMD_LISTEN: begin
            if (!slot_on(s) || conn[s].conn_state != CONN_CLOSED) begin
               st = STATUS_REFUSED;
            end else begin
               conn[s].conn_state = CONN_LISTEN;
            end
         end
         CMD_CONSUME: begin
            if (!slot_on(s) || conn[s].conn_state != CONN_OPEN) begin
               st = STATUS_REFUSED;
            end else if (d.read_length > conn[s].used_bytes) begin
               st = STATUS_SHORT;
            end else begin
               conn[s].used_bytes = conn[s].used_bytes - d.read_length;
            end
         end
         default: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (conn[i].conn_state == CONN_CWAIT) begin
                  if (conn[i].closewait_count <= 1) begin
                     conn[i].closewait_count = '0;
                     conn[i].conn_state = CONN_CLOSED;
                     conn[i].used_bytes = '0;
                  end else begin
                     conn[i].closewait_count = conn[i].closewait_count - 1'b1;
                  end
               end
            end
         end
      endcase
      if (cmd != CMD_SEGMENT && s >= SLOTS) hit = 1'b0;
      r.body.status = st;
      if (hit) begin
         r.body.slot_state = conn[s].conn_state;
         r.body.buffered_bytes = conn[s].used_bytes;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %0h got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_replies.delete();
         enable_bits      = '0;
         local_port       = '{default: '0};
         closewait_reload = CLOSEWAIT_RESET;
         conn             = '{default: '0};
         outstanding     <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_ENABLE) begin
               enable_bits = csr_data[3:0];
            end else if (csr_index == REG_CLOSEWAIT) begin
               closewait_reload = csr_data;
            end else if (csr_index >= REG_PORT0 && csr_index < REG_PORT0 + SLOTS) begin
               local_port[csr_index - REG_PORT0] = csr_data;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $error("reply item with nothing outstanding");
               fail_count++;
            end else begin
               want = expected_replies.pop_front();
               seen = rsp_tdata[$bits(rsp_data_type)-1:0];
               check_field("reply_type", want.reply_type, rsp_tuser);
               check_field("reply_valid", want.body.reply_valid, seen.reply_valid);
               check_field("reply_node", want.body.reply_node, seen.reply_node);
               check_field("reply_to_port", want.body.reply_to_port, seen.reply_to_port);
               check_field("reply_from_port", want.body.reply_from_port,
                           seen.reply_from_port);
               check_field("reply_ack_num", want.body.reply_ack_num, seen.reply_ack_num);
               check_field("status", want.body.status, seen.status);
               check_field("slot_state", want.body.slot_state, seen.slot_state);
               check_field("buffered_bytes", want.body.buffered_bytes, seen.buffered_bytes);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_replies.push_back(
               predict_reply(req_tuser, req_tdata[$bits(req_data_type)-1:0]));
         end
         outstanding <= expected_replies.size();
      end
   end

endmodule

/* bench/tb_transport_receiver_connection_fsm.sv */
`timescale 1ns / 1ps

module tb_transport_receiver_connection_fsm
   import trcf_pkg::*;
();

   localparam int SLOTS       = 4;
   localparam int BUF_BYTES   = 4096;
   localparam int SETTLE      = 2 * SLOTS + 4;
   localparam int CYCLE_LIMIT = 500000;

   localparam logic [2:0] SEG_SYNACK  = 3'd1;
   localparam logic [2:0] SEG_FINACK  = 3'd3;
   localparam logic [2:0] SEG_DATAACK = 3'd5;
   localparam logic [2:0] SEG_UNDEF_A = 3'd6;
   localparam logic [2:0] SEG_UNDEF_B = 3'd7;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [103:0] req_tdata  = '0;
   logic [1:0]   req_tuser  = CMD_TICK;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid  = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index  = REG_ENABLE;
   logic [15:0]  csr_data   = '0;

   int outstanding;
   int fail_count;
   int cycle_count = 0;
   int gap_pct     = 0;
   int stall_pct   = 0;

   logic [3:0]  cfg_enable;
   logic [15:0] cfg_port [SLOTS];
   logic [15:0] cfg_cwait;
   logic [1:0]  sess_phase [SLOTS];
   logic [7:0]  sess_node [SLOTS];
   logic [15:0] sess_port [SLOTS];
   logic [31:0] sess_seq [SLOTS];
   int          sess_used [SLOTS];
   int          sess_wait [SLOTS];

   transport_receiver_connection_fsm #(
      .SLOTS     (SLOTS),
      .BUF_BYTES (BUF_BYTES)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   trcf_reply_checker #(
      .SLOTS     (SLOTS),
      .BUF_BYTES (BUF_BYTES)
   ) reply_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   function automatic req_data_type random_fields();
      req_data_type d;
      d.slot        = 2'($urandom_range(3));
      d.seg_type    = 3'($urandom_range(7));
      d.src_node    = 8'($urandom());
      d.from_port   = 16'($urandom());
      d.to_port     = 16'($urandom());
      d.seq_num     = $urandom();
      d.seg_length  = 13'($urandom_range(4096));
      d.read_length = 13'($urandom_range(4096));
      return d;
   endfunction

   // segment types the receiver never acts on
   function automatic logic [2:0] stray_kind();
      case ($urandom_range(4))
         0: return SEG_SYNACK;
         1: return SEG_FINACK;
         2: return SEG_DATAACK;
         3: return SEG_UNDEF_A;
         default: return SEG_UNDEF_B;
      endcase
   endfunction

   // enabled slot that segments can actually reach, or -1
   function automatic int pick_slot();
      int s;
      logic ok;
      for (int tries = 0; tries < 8; tries++) begin
         s = $urandom_range(SLOTS - 1);
         ok = cfg_enable[s];
         for (int j = 0; j < s; j++) begin
            if (cfg_enable[j] && cfg_port[j] == cfg_port[s]) ok = 1'b0;
         end
         if (ok) return s;
      end
      return -1;
   endfunction

   task automatic send_item(input logic [1:0] cmd, input req_data_type d);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, d};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_segment(input logic [2:0] kind, input logic [7:0] node,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input logic [31:0] seq, input logic [12:0] len);
      req_data_type d;
      d = random_fields();
      d.seg_type   = kind;
      d.src_node   = node;
      d.from_port  = sport;
      d.to_port    = dport;
      d.seq_num    = seq;
      d.seg_length = len;
      send_item(CMD_SEGMENT, d);
   endtask

   task automatic send_command(input logic [1:0] cmd, input logic [1:0] slot,
                               input logic [12:0] rlen);
      req_data_type d;
      d = random_fields();
      d.slot        = slot;
      d.read_length = rlen;
      send_item(cmd, d);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_settings(input logic [3:0] en, input logic [15:0] p0,
                                input logic [15:0] p1, input logic [15:0] p2,
                                input logic [15:0] p3, input logic [15:0] cw);
      wait_idle();
      cfg_enable  = en;
      cfg_port[0] = p0;
      cfg_port[1] = p1;
      cfg_port[2] = p2;
      cfg_port[3] = p3;
      cfg_cwait   = cw;
      write_reg(REG_ENABLE, en);
      for (int i = 0; i < SLOTS; i++) write_reg(3'(REG_PORT0 + i), cfg_port[i]);
      write_reg(REG_CLOSEWAIT, cw);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed connection lifecycles, interleaved across slots, plus noise
   task automatic play_sessions(input int count);
      req_data_type d;
      logic [1:0] cmd;
      int s;
      int len;
      int pick;
      repeat (count) begin
         d = random_fields();
         s = pick_slot();
         if (s < 0 || $urandom_range(99) < 12) begin
            cmd = 2'($urandom_range(3));
            if ($urandom_range(1)) d.to_port = cfg_port[$urandom_range(SLOTS - 1)];
         end else begin
            d.slot      = 2'(s);
            d.to_port   = cfg_port[s];
            d.src_node  = sess_node[s];
            d.from_port = sess_port[s];
            d.seq_num   = sess_seq[s];
            cmd         = CMD_SEGMENT;
            pick        = $urandom_range(99);
            case (sess_phase[s])
               CONN_CLOSED: begin
                  cmd = CMD_LISTEN;
                  sess_phase[s] = CONN_LISTEN;
               end
               CONN_LISTEN: begin
                  d.seg_type    = SEG_SYN;
                  d.src_node    = 8'($urandom());
                  d.from_port   = 16'($urandom());
                  d.seq_num     = $urandom();
                  sess_node[s]  = d.src_node;
                  sess_port[s]  = d.from_port;
                  sess_seq[s]   = d.seq_num;
                  sess_phase[s] = CONN_OPEN;
               end
               CONN_OPEN: begin
                  if (pick < 55) begin
                     len = ($urandom_range(99) < 85) ? $urandom_range(300)
                                                     : $urandom_range(4096);
                     d.seg_type   = SEG_DATA;
                     d.seg_length = 13'(len);
                     if (sess_used[s] + len < BUF_BYTES) begin
                        sess_used[s] += len;
                        sess_seq[s] = sess_seq[s] + len;
                     end
                  end else if (pick < 75) begin
                     cmd = CMD_CONSUME;
                     len = ($urandom_range(99) < 70) ? $urandom_range(sess_used[s])
                                                     : $urandom_range(sess_used[s] + 50);
                     d.read_length = 13'(len);
                     if (len <= sess_used[s]) sess_used[s] -= len;
                  end else if (pick < 83) begin
                     d.seg_type    = SEG_FIN;
                     sess_phase[s] = CONN_CWAIT;
                     sess_wait[s]  = cfg_cwait;
                  end else if (pick < 87) begin
                     d.seg_type  = SEG_SYN;
                     d.seq_num   = $urandom();
                     sess_seq[s] = d.seq_num;
                  end else if (pick < 93) begin
                     d.seg_type = SEG_DATA;
                     d.seq_num  = sess_seq[s] + $urandom_range(1, 1000);
                  end else begin
                     d.seg_type = stray_kind();
                  end
               end
               default: begin
                  if (pick < 75) begin
                     cmd = CMD_TICK;
                  end else if (pick < 90) begin
                     d.seg_type = SEG_FIN;
                  end else begin
                     d.seg_type = $urandom_range(1) ? SEG_DATA : stray_kind();
                  end
               end
            endcase
         end
         if (cmd == CMD_TICK) begin
            for (int i = 0; i < SLOTS; i++) begin
               if (sess_phase[i] == CONN_CWAIT) begin
                  if (sess_wait[i] <= 1) begin
                     sess_phase[i] = CONN_CLOSED;
                     sess_used[i]  = 0;
                  end else begin
                     sess_wait[i]--;
                  end
               end
            end
         end
         send_item(cmd, d);
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         sess_phase[i] = CONN_CLOSED;
         sess_node[i]  = '0;
         sess_port[i]  = '0;
         sess_seq[i]   = '0;
         sess_used[i]  = 0;
         sess_wait[i]  = 0;
      end
      gap_pct   = 6;
      stall_pct = 71;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no slot enabled
      send_segment(SEG_SYN, 8'h00, 16'h0000, 16'h0000, 32'h0, 13'd0);
      send_command(CMD_LISTEN, 2'd3, 13'd0);

      // duplicate port on slots two and three, close wait of zero
      load_settings(4'hF, 16'h0000, 16'hFFFF, 16'h5A5A, 16'h5A5A, 16'h0000);
      send_segment(SEG_SYN, 8'hFF, 16'hFFFF, 16'h0000, 32'h0, 13'd0);
      send_command(CMD_LISTEN, 2'd0, 13'd0);
      send_command(CMD_LISTEN, 2'd0, 13'd0);
      send_segment(SEG_FIN, 8'hFF, 16'hFFFF, 16'h0000, 32'h0, 13'd0);
      send_segment(SEG_SYN, 8'hFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFF0, 13'd0);
      // sequence wraps past zero
      send_segment(SEG_DATA, 8'hFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFF0, 13'd32);
      send_segment(SEG_DATA, 8'h01, 16'hFFFF, 16'h0000, 32'h10, 13'd5);
      send_segment(SEG_DATA, 8'hFF, 16'hFFFF, 16'h0000, 32'h5, 13'd7);
      // buffer full: dropped, then exactly one byte short of capacity
      send_segment(SEG_DATA, 8'hFF, 16'hFFFF, 16'h0000, 32'h10, 13'd4096);
      send_segment(SEG_DATA, 8'hFF, 16'hFFFF, 16'h0000, 32'h10, 13'd4063);
      send_command(CMD_CONSUME, 2'd0, 13'd4096);
      send_command(CMD_CONSUME, 2'd0, 13'd4095);
      send_segment(SEG_UNDEF_A, 8'hFF, 16'hFFFF, 16'h0000, 32'h0, 13'd0);
      send_segment(SEG_SYN, 8'hFF, 16'hFFFF, 16'h0000, 32'h0, 13'd0);
      send_command(CMD_LISTEN, 2'd2, 13'd0);
      send_segment(SEG_SYN, 8'h00, 16'h0000, 16'h5A5A, 32'h8000_0000, 13'd0);
      send_segment(SEG_FIN, 8'hFF, 16'hFFFF, 16'h0000, 32'h0, 13'd0);
      send_segment(SEG_FIN, 8'hFF, 16'hFFFF, 16'h0000, 32'h0, 13'd0);
      send_segment(SEG_DATA, 8'hFF, 16'hFFFF, 16'h0000, 32'h0, 13'd1);
      send_segment(SEG_FIN, 8'h00, 16'h0000, 16'h5A5A, 32'h0, 13'd0);
      send_command(CMD_TICK, 2'd0, 13'd0);
      send_command(CMD_CONSUME, 2'd2, 13'd0);
      send_segment(SEG_DATA, 8'h00, 16'h0000, 16'h1234, 32'h0, 13'd0);

      load_settings(4'hF, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                    16'($urandom()), 16'd2);
      play_sessions(300);

      load_settings(4'b0110, 16'h0000, 16'hFFFF, 16'($urandom()), 16'($urandom()), 16'd1);
      gap_pct   = 71;
      stall_pct = 6;
      play_sessions(300);

      load_settings(4'hF, 16'h7777, 16'($urandom()), 16'h7777, 16'($urandom()), 16'd0);
      gap_pct   = 0;
      stall_pct = 0;
      play_sessions(250);

      load_settings(4'hF, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                    16'($urandom()), 16'hFFFF);
      play_sessions(150);

      wait_idle();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
